// ===== rtl/pde_pkg.sv =====
// Shared types, constants and register map for the pulse-distance line encoder.
// No dependencies; imported by every module of the block.
package pde_pkg;

    localparam int DUR_W = 15;

    localparam int NUM_REGS = 7;
    localparam int CFG_IDX_W = $clog2(NUM_REGS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEAD_LOW  = 3'd0,
        REG_LEAD_HIGH = 3'd1,
        REG_BIT_LOW   = 3'd2,
        REG_ONE_HIGH  = 3'd3,
        REG_ZERO_HIGH = 3'd4,
        REG_STOP      = 3'd5,
        REG_END       = 3'd6
    } reg_idx_t;

    localparam logic [DUR_W-1:0] RST_LEAD_LOW  = DUR_W'(1800);
    localparam logic [DUR_W-1:0] RST_LEAD_HIGH = DUR_W'(900);
    localparam logic [DUR_W-1:0] RST_BIT_LOW   = DUR_W'(100);
    localparam logic [DUR_W-1:0] RST_ONE_HIGH  = DUR_W'(300);
    localparam logic [DUR_W-1:0] RST_ZERO_HIGH = DUR_W'(100);
    localparam logic [DUR_W-1:0] RST_STOP      = DUR_W'(100);
    localparam logic [DUR_W-1:0] RST_END       = DUR_W'(200);

    typedef enum logic [2:0] {
        KIND_LEAD = 3'd0,
        KIND_ZERO = 3'd1,
        KIND_ONE  = 3'd2,
        KIND_STOP = 3'd3,
        KIND_END  = 3'd4
    } kind_t;

    // symbol sequence of one byte: lead, eight bits MSB first, stop, end
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_LEAD      = 4'd0;
    localparam logic [STEP_W-1:0] STEP_BIT_FIRST = 4'd1;
    localparam logic [STEP_W-1:0] STEP_BIT_LAST  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_STOP      = 4'd9;
    localparam logic [STEP_W-1:0] STEP_END       = 4'd10;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [DUR_W-1:0] lead_low;
        logic [DUR_W-1:0] lead_high;
        logic [DUR_W-1:0] bit_low;
        logic [DUR_W-1:0] one_high;
        logic [DUR_W-1:0] zero_high;
        logic [DUR_W-1:0] stop;
        logic [DUR_W-1:0] fin;
    } cfg_t;

    typedef struct packed {
        logic [7:0]        data;
        logic [STEP_W-1:0] start_step;
        logic [STEP_W-1:0] final_step;
        logic              port;
    } item_t;

    typedef struct packed {
        logic  valid;
        logic  full;
        item_t item;
    } q_status_t;

endpackage

// ===== rtl/pde_front.sv =====
// Front end: registers an accepted byte and classifies it into a symbol range.
// Depends on pde_pkg; feeds pde_queue.
module pde_front
    import pde_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  logic  [7:0] data_byte,
    input  logic  first_byte,
    input  logic  last_byte,
    input  logic  port_select,
    input  logic  q_full,
    output logic  f_push,
    output item_t f_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign f_push = valid_reg && !q_full;
    assign f_item = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (f_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.data       <= data_byte;
            item_reg.start_step <= first_byte ? STEP_LEAD : STEP_BIT_FIRST;
            item_reg.final_step <= last_byte ? STEP_END : STEP_BIT_LAST;
            item_reg.port       <= port_select;
        end
    end

endmodule

// ===== rtl/pde_queue.sv =====
// Short item queue between the front end and the symbol sequencer.
// Depends on pde_pkg.
module pde_queue
    import pde_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr,
    input  item_t     wr_item,
    input  logic      rd,
    output q_status_t status
);

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_wr;
    logic              do_rd;

    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign status.item  = mem_reg[rd_ptr_reg];

    assign do_wr = wr && !status.full;
    assign do_rd = rd && status.valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== rtl/pde_back.sv =====
// Back end: steps a byte's symbols into the result register, one symbol per cycle while
// it is free or being popped. Depends on pde_pkg; reads items from pde_queue.
module pde_back
    import pde_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  q_status_t        q_status,
    output logic             q_rd,
    input  logic             pop,
    output logic             empty,
    output logic [DUR_W-1:0] low_ticks,
    output logic [DUR_W-1:0] high_ticks,
    output logic [2:0]       symbol_kind,
    output logic             port,
    output logic             end_of_message
);

    logic              busy_reg;
    logic              busy_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    item_t             item_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DUR_W-1:0]  out_low_reg;
    logic [DUR_W-1:0]  out_high_reg;
    kind_t             out_kind_reg;
    logic              out_port_reg;
    logic              out_eom_reg;

    logic              adv;
    logic              done;
    logic              load;
    logic [2:0]        bit_idx;
    logic [DUR_W-1:0]  sym_low;
    logic [DUR_W-1:0]  sym_high;
    kind_t             sym_kind;

    assign adv     = busy_reg && (!out_valid_reg || pop);
    assign done    = adv && (step_reg == item_reg.final_step);
    assign load    = q_status.valid && (!busy_reg || done);
    assign q_rd    = load;
    assign bit_idx = 3'(STEP_BIT_LAST - step_reg);

    always_comb
    begin
        case (step_reg)
            STEP_LEAD:
            begin
                sym_low  = cfg.lead_low;
                sym_high = cfg.lead_high;
                sym_kind = KIND_LEAD;
            end
            STEP_STOP:
            begin
                sym_low  = cfg.stop;
                sym_high = cfg.stop;
                sym_kind = KIND_STOP;
            end
            STEP_END:
            begin
                sym_low  = cfg.fin;
                sym_high = cfg.fin;
                sym_kind = KIND_END;
            end
            default:
            begin
                sym_low  = cfg.bit_low;
                sym_high = item_reg.data[bit_idx] ? cfg.one_high : cfg.zero_high;
                sym_kind = item_reg.data[bit_idx] ? KIND_ONE : KIND_ZERO;
            end
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (load)
        begin
            busy_next = 1'b1;
            step_next = q_status.item.start_step;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (adv)
        begin
            step_next = step_reg + 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_LEAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= q_status.item;
        end
        if (adv)
        begin
            out_low_reg  <= sym_low;
            out_high_reg <= sym_high;
            out_kind_reg <= sym_kind;
            out_port_reg <= item_reg.port;
            out_eom_reg  <= (sym_kind == KIND_END);
        end
    end

    assign empty          = !out_valid_reg;
    assign low_ticks      = out_low_reg;
    assign high_ticks     = out_high_reg;
    assign symbol_kind    = out_kind_reg;
    assign port           = out_port_reg;
    assign end_of_message = out_eom_reg;

endmodule

// ===== rtl/pulse_distance_line_encoder.sv =====
// Pulse-distance line encoder top level: duration registers, front end, item queue, sequencer.
// Depends on pde_pkg, pde_front, pde_queue, pde_back.
// Path: an accepted byte is registered in the front end, written to the item queue, then
// loaded by the sequencer. One symbol per cycle from the sequencer while pop keeps up; a byte
// gives 8 to 11 symbols (eight data symbols, plus lead-in and stop/end when flagged).
// Reset: asynchronous, active low; empties the queue and result register, durations to defaults.
module pulse_distance_line_encoder
    import pde_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           data_byte,
    input  logic                 first_byte,
    input  logic                 last_byte,
    input  logic                 port_select,
    output logic                 empty,
    input  logic                 pop,
    output logic [DUR_W-1:0]     low_ticks,
    output logic [DUR_W-1:0]     high_ticks,
    output logic [2:0]           symbol_kind,
    output logic                 port,
    output logic                 end_of_message,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]     cfg_data
);

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    logic      f_push;
    item_t     f_item;
    q_status_t q_status;
    logic      q_rd;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_LEAD_LOW:  cfg_next.lead_low  = cfg_data;
                REG_LEAD_HIGH: cfg_next.lead_high = cfg_data;
                REG_BIT_LOW:   cfg_next.bit_low   = cfg_data;
                REG_ONE_HIGH:  cfg_next.one_high  = cfg_data;
                REG_ZERO_HIGH: cfg_next.zero_high = cfg_data;
                REG_STOP:      cfg_next.stop      = cfg_data;
                REG_END:       cfg_next.fin       = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lead_low  <= RST_LEAD_LOW;
            cfg_reg.lead_high <= RST_LEAD_HIGH;
            cfg_reg.bit_low   <= RST_BIT_LOW;
            cfg_reg.one_high  <= RST_ONE_HIGH;
            cfg_reg.zero_high <= RST_ZERO_HIGH;
            cfg_reg.stop      <= RST_STOP;
            cfg_reg.fin       <= RST_END;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pde_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .first_byte  (first_byte),
        .last_byte   (last_byte),
        .port_select (port_select),
        .q_full      (q_status.full),
        .f_push      (f_push),
        .f_item      (f_item)
    );

    pde_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (f_push),
        .wr_item (f_item),
        .rd      (q_rd),
        .status  (q_status)
    );

    pde_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_status       (q_status),
        .q_rd           (q_rd),
        .pop            (pop),
        .empty          (empty),
        .low_ticks      (low_ticks),
        .high_ticks     (high_ticks),
        .symbol_kind    (symbol_kind),
        .port           (port),
        .end_of_message (end_of_message)
    );

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        f_push |-> !q_status.full)
        else $error("queue written while full");

    a_no_read_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd |-> q_status.valid)
        else $error("queue read while empty");

    a_eom_on_end_only: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (end_of_message == (symbol_kind == KIND_END)))
        else $error("end of message flag on wrong symbol");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (symbol_kind == KIND_LEAD || symbol_kind == KIND_ZERO
                    || symbol_kind == KIND_ONE || symbol_kind == KIND_STOP
                    || symbol_kind == KIND_END))
        else $error("symbol kind out of range");

endmodule

// ===== dv/tb_pulse_distance_line_encoder.sv =====
// Testbench for pulse_distance_line_encoder: queued bytes feed a clocked driver, a
// clocked monitor checks every symbol against a local symbol predictor.
// Depends on rtl/pde_pkg.sv and rtl/pulse_distance_line_encoder.sv.
module tb_pulse_distance_line_encoder
    import pde_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BYTES = 28;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam logic [DUR_W-1:0] DUR_MAX = '1;

    typedef struct {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       port;
    } byte_req_t;

    typedef struct {
        logic [DUR_W-1:0] lo;
        logic [DUR_W-1:0] hi;
        kind_t            kind;
        logic             port;
        logic             eom;
    } symbol_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    byte_req_t            tx_byte = '{8'h00, 1'b0, 1'b0, 1'b0};
    logic                 empty;
    logic                 pop = 1'b0;
    logic [DUR_W-1:0]     low_ticks;
    logic [DUR_W-1:0]     high_ticks;
    logic [2:0]           symbol_kind;
    logic                 port;
    logic                 end_of_message;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DUR_W-1:0]     cfg_data = '0;

    byte_req_t        byte_pending_q[$];
    symbol_t          symbol_expect_q[$];
    symbol_t          mon_exp;
    logic [DUR_W-1:0] dur_shadow[NUM_REGS];
    int               tx_idle_pct = 15;
    int               rx_idle_pct = 78;
    int               errors = 0;
    int               bytes_sent = 0;
    int               symbols_seen = 0;
    int               cfg_writes = 0;
    int               settings_run = 0;
    int               quiet_cycles = 0;

    pulse_distance_line_encoder uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (tx_byte.data),
        .first_byte     (tx_byte.first),
        .last_byte      (tx_byte.last),
        .port_select    (tx_byte.port),
        .empty          (empty),
        .pop            (pop),
        .low_ticks      (low_ticks),
        .high_ticks     (high_ticks),
        .symbol_kind    (symbol_kind),
        .port           (port),
        .end_of_message (end_of_message),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic push_symbol(logic [DUR_W-1:0] lo, logic [DUR_W-1:0] hi, kind_t kind,
                               logic p, logic eom);
        symbol_t s;
        s.lo = lo;
        s.hi = hi;
        s.kind = kind;
        s.port = p;
        s.eom = eom;
        symbol_expect_q = {symbol_expect_q, s};
    endtask

    // lead-in when first, eight data symbols MSB first, then stop and end when last
    task automatic encode_byte(byte_req_t b);
        if (b.first)
            push_symbol(dur_shadow[REG_LEAD_LOW], dur_shadow[REG_LEAD_HIGH], KIND_LEAD,
                        b.port, 1'b0);
        for (int i = 7; i >= 0; i--)
        begin
            if (b.data[i])
                push_symbol(dur_shadow[REG_BIT_LOW], dur_shadow[REG_ONE_HIGH], KIND_ONE,
                            b.port, 1'b0);
            else
                push_symbol(dur_shadow[REG_BIT_LOW], dur_shadow[REG_ZERO_HIGH], KIND_ZERO,
                            b.port, 1'b0);
        end
        if (b.last)
        begin
            push_symbol(dur_shadow[REG_STOP], dur_shadow[REG_STOP], KIND_STOP, b.port, 1'b0);
            push_symbol(dur_shadow[REG_END], dur_shadow[REG_END], KIND_END, b.port, 1'b1);
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                encode_byte(tx_byte);
                void'(byte_pending_q.pop_front());
                bytes_sent++;
            end
            if (!(push && full))
            begin
                if (byte_pending_q.size() > 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    push <= 1'b1;
                    tx_byte <= byte_pending_q[0];
                end
                else
                    push <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                symbols_seen++;
                if (symbol_expect_q.size() == 0)
                    report_mismatch("unexpected symbol, kind", 32'(symbol_kind), 0);
                else
                begin
                    mon_exp = symbol_expect_q.pop_front();
                    if (low_ticks !== mon_exp.lo)
                        report_mismatch("low_ticks", 32'(low_ticks), 32'(mon_exp.lo));
                    if (high_ticks !== mon_exp.hi)
                        report_mismatch("high_ticks", 32'(high_ticks), 32'(mon_exp.hi));
                    if (symbol_kind !== mon_exp.kind)
                        report_mismatch("symbol_kind", 32'(symbol_kind), 32'(mon_exp.kind));
                    if (port !== mon_exp.port)
                        report_mismatch("port", 32'(port), 32'(mon_exp.port));
                    if (end_of_message !== mon_exp.eom)
                        report_mismatch("end_of_message", 32'(end_of_message),
                                        32'(mon_exp.eom));
                end
            end
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_duration(logic [CFG_IDX_W-1:0] idx, logic [DUR_W-1:0] val);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx < NUM_REGS)
            dur_shadow[idx] = val;
        cfg_writes++;
    endtask

    task automatic add_byte(logic [7:0] data, logic first, logic last, logic p);
        byte_req_t b;
        b.data = data;
        b.first = first;
        b.last = last;
        b.port = p;
        byte_pending_q = {byte_pending_q, b};
    endtask

    // mostly complete messages, some bytes with random flags
    task automatic add_random_bytes(int n);
        int   added;
        int   len;
        logic p;
        added = 0;
        while (added < n)
        begin
            if ($urandom_range(9) < 8)
            begin
                len = $urandom_range(4, 1);
                p = 1'($urandom_range(1));
                for (int i = 0; i < len; i++)
                    add_byte(8'($urandom_range(255)), i == 0, i == len - 1, p);
                added += len;
            end
            else
            begin
                add_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
                added++;
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (byte_pending_q.size() != 0 || push || symbol_expect_q.size() != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_idle(int tx_pct, int rx_pct);
        @(negedge clk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    initial
    begin
        dur_shadow[REG_LEAD_LOW]  = RST_LEAD_LOW;
        dur_shadow[REG_LEAD_HIGH] = RST_LEAD_HIGH;
        dur_shadow[REG_BIT_LOW]   = RST_BIT_LOW;
        dur_shadow[REG_ONE_HIGH]  = RST_ONE_HIGH;
        dur_shadow[REG_ZERO_HIGH] = RST_ZERO_HIGH;
        dur_shadow[REG_STOP]      = RST_STOP;
        dur_shadow[REG_END]       = RST_END;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset durations
        set_idle(15, 78);
        settings_run++;
        add_byte(8'h00, 1'b1, 1'b1, 1'b0);
        add_byte(8'hFF, 1'b1, 1'b1, 1'b1);
        add_byte(8'hA5, 1'b1, 1'b0, 1'b1);
        add_byte(8'h5A, 1'b0, 1'b0, 1'b1);
        add_byte(8'h80, 1'b0, 1'b0, 1'b1);
        add_byte(8'h01, 1'b0, 1'b1, 1'b1);
        add_byte(8'h3C, 1'b0, 1'b1, 1'b0);
        add_byte(8'hC3, 1'b1, 1'b0, 1'b0);
        add_byte(8'h7E, 1'b1, 1'b0, 1'b1);
        add_byte(8'h0F, 1'b0, 1'b0, 1'b0);
        add_byte(8'hF0, 1'b0, 1'b1, 1'b0);
        add_byte(8'h55, 1'b0, 1'b0, 1'b1);
        add_byte(8'hAA, 1'b1, 1'b1, 1'b0);
        add_random_bytes(RANDOM_BYTES);
        wait_drained();

        // extremes, then an unmapped index that must leave them alone
        settings_run++;
        write_duration(REG_LEAD_LOW, '0);
        write_duration(REG_LEAD_HIGH, DUR_MAX);
        write_duration(REG_BIT_LOW, DUR_MAX);
        write_duration(REG_ONE_HIGH, '0);
        write_duration(REG_ZERO_HIGH, DUR_MAX);
        write_duration(REG_STOP, '0);
        write_duration(REG_END, DUR_MAX);
        write_duration(REG_UNMAPPED, 15'h2AAA);
        add_byte(8'h96, 1'b1, 1'b1, 1'b1);
        add_byte(8'h69, 1'b1, 1'b1, 1'b0);
        add_random_bytes(RANDOM_BYTES);
        wait_drained();

        set_idle(78, 15);
        settings_run++;
        write_duration(REG_LEAD_LOW, DUR_MAX);
        write_duration(REG_LEAD_HIGH, '0);
        write_duration(REG_BIT_LOW, '0);
        write_duration(REG_ONE_HIGH, DUR_MAX);
        write_duration(REG_ZERO_HIGH, '0);
        write_duration(REG_STOP, DUR_MAX);
        write_duration(REG_END, '0);
        add_byte(8'h96, 1'b1, 1'b1, 1'b0);
        add_byte(8'h69, 1'b1, 1'b1, 1'b1);
        add_random_bytes(RANDOM_BYTES);
        wait_drained();

        set_idle(0, 0);
        settings_run++;
        for (int i = 0; i < NUM_REGS; i++)
            write_duration(CFG_IDX_W'(i), DUR_W'($urandom_range(32767)));
        add_random_bytes(RANDOM_BYTES);
        wait_drained();
        repeat (10) @(posedge clk);

        $display("Encoded %0d bytes into %0d symbols under %0d duration settings",
                 bytes_sent, symbols_seen, settings_run);
        $display("%0d register writes, %0d mismatches", cfg_writes, errors);
        if (errors == 0 && symbol_expect_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pde_pkg.sv
rtl/pde_front.sv
rtl/pde_queue.sv
rtl/pde_back.sv
rtl/pulse_distance_line_encoder.sv
dv/tb_pulse_distance_line_encoder.sv
